[rtl/assert_macros.svh]
// Assertion helpers; both sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define MKM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// When pre holds, post must hold in the following cycle.
`define MKM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

[rtl/mkm_pkg.sv]
package mkm_pkg;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_AB = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_AX = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_BX = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_A0 = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DD = 3'd4;

  // 0.229 with 16 fraction bits
  localparam logic [13:0] GAMMA_Q16 = 14'd15008;

  localparam logic [23:0] RBE_MAX = 24'hFFFFFF;

  // per-item flags and dose that ride along the pipeline
  typedef struct packed {
    logic [23:0] dose;
    logic        zero;
    logic        sat;
    logic        lt;
  } side_t;

endpackage

[rtl/mkm_div_pipe.sv]
// Restoring divider, one quotient bit per stage. The caller guarantees
// rem_i < div_i; otherwise the quotient is meaningless.
module mkm_div_pipe #(
  parameter int QW = 40,
  parameter int DW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DW-1:0]   rem_i,
  input  logic [QW-1:0]   num_i,
  input  logic [DW-1:0]   div_i,
  input  mkm_pkg::side_t  side_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o,
  output mkm_pkg::side_t  side_o
);
  import mkm_pkg::*;

  logic [DW+QW-1:0] acc_q [QW];
  logic [DW+QW-1:0] acc_d [QW];
  logic [DW-1:0]    div_q [QW];
  side_t            side_q [QW];
  logic [QW-1:0]    v_q;

  // upper DW bits: partial remainder; lower bits: numerator out, quotient in
  function automatic logic [DW+QW-1:0] div_step(input logic [DW+QW-1:0] a,
                                                 input logic [DW-1:0] dv);
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rnew;
    trial = {a[DW+QW-1:QW], a[QW-1]};
    ge    = trial >= {1'b0, dv};
    rnew  = ge ? DW'(trial - {1'b0, dv}) : trial[DW-1:0];
    return {rnew, a[QW-2:0], ge};
  endfunction

  always_comb begin
    acc_d[0] = div_step({rem_i, num_i}, div_i);
    for (int k = 1; k < QW; k++) begin
      acc_d[k] = div_step(acc_q[k-1], div_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0]  <= acc_d[0];
      div_q[0]  <= div_i;
      side_q[0] <= side_i;
      for (int k = 1; k < QW; k++) begin
        acc_q[k]  <= acc_d[k];
        div_q[k]  <= div_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = acc_q[QW-1][QW-1:0];
  assign side_o  = side_q[QW-1];

endmodule

[rtl/mkm_sqrt_pipe.sv]
// Integer square root of a 64-bit word, one root bit per stage.
module mkm_sqrt_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [63:0]     rad_i,
  input  mkm_pkg::side_t  side_i,
  output logic            valid_o,
  output logic [31:0]     root_o,
  output mkm_pkg::side_t  side_o
);
  import mkm_pkg::*;

  localparam int NS = 32;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] xs;
  } sq_t;

  sq_t           st_q [NS];
  sq_t           st_d [NS];
  side_t         side_q [NS];
  logic [NS-1:0] v_q;

  function automatic sq_t sq_step(input sq_t s);
    logic [34:0] r;
    logic [34:0] trial;
    logic        ge;
    sq_t         o;
    r      = {s.rem[32:0], s.xs[63:62]};
    trial  = {1'b0, s.root, 2'b01};
    ge     = r >= trial;
    o.rem  = ge ? 34'(r - trial) : r[33:0];
    o.root = {s.root[30:0], ge};
    o.xs   = {s.xs[61:0], 2'b00};
    return o;
  endfunction

  always_comb begin
    st_d[0] = sq_step('{rem: '0, root: '0, xs: rad_i});
    for (int k = 1; k < NS; k++) begin
      st_d[k] = sq_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= st_d[0];
      side_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        st_q[k]   <= st_d[k];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign root_o  = st_q[NS-1].root;
  assign side_o  = side_q[NS-1];

endmodule

[rtl/mkm_let_rbe_from_dose.sv]
// channel | dir | handshake              | payload
// in      | in  | in_valid_i/in_stall_o  | dose_i, let_dose_avg_i
// out     | out | out_valid_o/out_stall_i| rbe_o, clipped_o
// cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle while not stalled; items pass through the three
// bit-per-stage dividers (40, 61, 24 stages) and the 32-stage square root.
// A stall while out_valid_o is high freezes the pipeline in the same cycle.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// cfg_ready_o is always high.
`include "assert_macros.svh"

module mkm_let_rbe_from_dose (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [23:0]               dose_i,
  input  logic [19:0]               let_dose_avg_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [23:0]               rbe_o,
  output logic                      clipped_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mkm_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [23:0]               cfg_data_i
);
  import mkm_pkg::*;

  logic [23:0] ab_q;
  logic [19:0] ax_q, bx_q, a0_q, dd_q;
  logic [39:0] dd2_q;
  logic [47:0] abab_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_q   <= '0;
      ax_q   <= 20'h10000;
      bx_q   <= '0;
      a0_q   <= '0;
      dd_q   <= 20'h10000;
      dd2_q  <= 40'h1_0000_0000;
      abab_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_AB:  ab_q <= cfg_data_i;
          CFG_AX:  ax_q <= cfg_data_i[19:0];
          CFG_BX:  bx_q <= cfg_data_i[19:0];
          CFG_A0:  a0_q <= cfg_data_i[19:0];
          CFG_DD:  dd_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      // squares of static registers, ready before an item reaches them
      dd2_q  <= 40'(dd_q) * 40'(dd_q);
      abab_q <= 48'(ab_q) * 48'(ab_q);
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: t = 0.229 * LET
  logic        s1_v_q;
  logic [23:0] s1_d_q;
  logic [33:0] s1_t_q;
  logic        s1_sat_q;

  // stage 3 and on
  logic        s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q, s9_v_q, s10_v_q;
  side_t       s3_side_q, s4_side_q, s5_side_q, s6_side_q, s7_side_q;
  side_t       s8_side_q, s9_side_q, s10_side_q;
  logic [59:0] s3_p_q;
  logic [39:0] s4_alpha_q;
  logic [63:0] s5_m_q;
  logic [55:0] s6_pl_q, s6_ph_q;
  logic [87:0] s7_prod_q;
  logic [60:0] s8_q_q;
  logic [47:0] s8_dsq_q;
  logic [63:0] s9_r4_q;
  logic [31:0] s10_num_q;

  logic [23:0] rbe_q;
  logic        clipped_q;

  // gamma divider
  side_t       g_side_in, g_side;
  logic        g_v;
  logic [39:0] g_quo;

  always_comb begin
    g_side_in.dose = s1_d_q;
    g_side_in.zero = (s1_d_q == '0);
    g_side_in.sat  = s1_sat_q || (40'(s1_t_q[33:18]) >= dd2_q);
    g_side_in.lt   = 1'b0;
  end

  mkm_div_pipe #(.QW(40), .DW(40)) u_div_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_v_q),
    .rem_i   (40'(s1_t_q[33:18])),
    .num_i   ({s1_t_q[17:0], 22'd0}),
    .div_i   (dd2_q),
    .side_i  (g_side_in),
    .valid_o (g_v),
    .quo_o   (g_quo),
    .side_o  (g_side)
  );

  // q divider
  side_t       q_side_in, q_side;
  logic        q_v;
  logic [60:0] q_quo;

  always_comb begin
    q_side_in     = s7_side_q;
    q_side_in.sat = s7_side_q.sat || (s7_prod_q[87:61] >= 27'(ax_q));
  end

  mkm_div_pipe #(.QW(61), .DW(20)) u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .rem_i   (s7_prod_q[80:61]),
    .num_i   (s7_prod_q[60:0]),
    .div_i   (ax_q),
    .side_i  (q_side_in),
    .valid_o (q_v),
    .quo_o   (q_quo),
    .side_o  (q_side)
  );

  // square root of four times the radicand
  side_t       r_side;
  logic        r_v;
  logic [31:0] r_root;

  mkm_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s9_v_q),
    .rad_i   (s9_r4_q),
    .side_i  (s9_side_q),
    .valid_o (r_v),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  // final divider by 2d
  side_t       f_side_in, f_side;
  logic        f_v;
  logic [23:0] f_quo;

  always_comb begin
    f_side_in     = s10_side_q;
    // a negative result outranks overflow of the last quotient
    f_side_in.sat = s10_side_q.sat ||
                    ((25'(s10_num_q[31:8]) >= {s10_side_q.dose, 1'b0}) && !s10_side_q.lt);
  end

  mkm_div_pipe #(.QW(24), .DW(25)) u_div_rbe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s10_v_q),
    .rem_i   (25'(s10_num_q[31:8])),
    .num_i   ({s10_num_q[7:0], 16'd0}),
    .div_i   ({s10_side_q.dose, 1'b0}),
    .side_i  (f_side_in),
    .valid_o (f_v),
    .quo_o   (f_quo),
    .side_o  (f_side)
  );

  logic [44:0] alpha_sum;
  assign alpha_sum = 45'(a0_q) + 45'(s3_p_q[59:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      s9_v_q      <= 1'b0;
      s10_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= in_valid_i;
      s3_v_q      <= g_v;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= q_v;
      s9_v_q      <= s8_v_q;
      s10_v_q     <= r_v;
      out_valid_q <= f_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d_q   <= dose_i;
      s1_t_q   <= 34'(GAMMA_Q16) * 34'(let_dose_avg_i);
      s1_sat_q <= (ax_q == '0) || (dd_q == '0);

      s3_side_q <= g_side;
      s3_p_q    <= 60'(g_quo) * 60'(bx_q);

      s4_side_q  <= '{dose: s3_side_q.dose, zero: s3_side_q.zero,
                      sat: s3_side_q.sat || (alpha_sum[44:40] != '0), lt: s3_side_q.lt};
      s4_alpha_q <= alpha_sum[39:0];

      s5_side_q <= s4_side_q;
      s5_m_q    <= 64'(s4_alpha_q) * 64'(ab_q);

      // split the wide product into two 32 x 24 halves
      s6_side_q <= s5_side_q;
      s6_pl_q   <= 56'(s5_m_q[31:0]) * 56'(s5_side_q.dose);
      s6_ph_q   <= 56'(s5_m_q[63:32]) * 56'(s5_side_q.dose);

      s7_side_q <= s6_side_q;
      s7_prod_q <= {s6_ph_q, 32'd0} + 88'(s6_pl_q);

      s8_side_q <= q_side;
      s8_q_q    <= q_quo;
      s8_dsq_q  <= 48'(q_side.dose) * 48'(q_side.dose);

      s9_side_q <= s8_side_q;
      s9_r4_q   <= 64'(abab_q) + {1'b0, s8_q_q, 2'b00} + 64'({s8_dsq_q, 2'b00});

      s10_side_q <= '{dose: r_side.dose, zero: r_side.zero, sat: r_side.sat,
                      lt: r_root < 32'(ab_q)};
      s10_num_q  <= r_root - 32'(ab_q);

      if (f_side.zero) begin
        rbe_q     <= '0;
        clipped_q <= 1'b0;
      end else if (f_side.sat) begin
        rbe_q     <= RBE_MAX;
        clipped_q <= 1'b1;
      end else if (f_side.lt) begin
        rbe_q     <= '0;
        clipped_q <= 1'b1;
      end else begin
        rbe_q     <= f_quo;
        clipped_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rbe_o       = rbe_q;
  assign clipped_o   = clipped_q;

  `MKM_ASSERT(a_clip_extreme, out_valid_q && clipped_q |-> (rbe_q == RBE_MAX || rbe_q == '0))
  `MKM_ASSERT_NEXT(a_hold_front, !en, $stable(s1_v_q))
  `MKM_ASSERT_NEXT(a_gamma_advance, en && g_v, s3_v_q)

endmodule

[sim/mkm_rbe_checker.sv]
module mkm_rbe_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [23:0]                dose_i,
  input  logic [19:0]                let_dose_avg_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [23:0]                rbe_i,
  input  logic                       clipped_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [mkm_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [23:0]                cfg_data_i,
  output int                         err_count_o,
  output int                         pending_o
);
  import mkm_pkg::*;

  typedef struct packed {
    logic [23:0] rbe;
    logic        clipped;
  } rbe_res_t;

  localparam logic [63:0] CAP40 = (64'd1 << 40) - 64'd1;
  localparam logic [63:0] CAP61 = (64'd1 << 61) - 64'd1;

  logic [23:0] ab_q;
  logic [19:0] ax_q, bx_q, a0_q, dd_q;
  rbe_res_t    rbe_expect_q[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bit_v;
    res   = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic rbe_res_t predict_rbe(logic [23:0] d, logic [19:0] let_v);
    rbe_res_t    r;
    logic [63:0] num, gamma, alpha, r4, s2, q64, prod, dsq;
    logic [127:0] q;
    r.rbe     = RBE_MAX;
    r.clipped = 1'b1;
    if (d == 0) begin
      r.rbe     = 0;
      r.clipped = 1'b0;
      return r;
    end
    if (ax_q == 0 || dd_q == 0) return r;
    num   = (64'd15008 * 64'(let_v)) << 22;
    dsq   = 64'(dd_q) * 64'(dd_q);
    gamma = num / dsq;
    if (gamma > CAP40) return r;
    alpha = 64'(a0_q) + ((gamma * 64'(bx_q)) >> 16);
    if (alpha > CAP40) return r;
    prod = alpha * 64'(ab_q);
    q    = (128'(prod) * 128'(d)) / 128'(ax_q);
    if (q > 128'(CAP61)) return r;
    q64 = q[63:0];
    r4  = 64'(ab_q) * 64'(ab_q) + (q64 << 2) + ((64'(d) * 64'(d)) << 2);
    s2  = floor_sqrt(r4);
    if (s2 < 64'(ab_q)) begin
      r.rbe = 0;
      return r;
    end
    num = ((s2 - 64'(ab_q)) << 16) / (64'(d) << 1);
    if (num > 64'hFFFFFF) return r;
    r.rbe     = num[23:0];
    r.clipped = 1'b0;
    return r;
  endfunction

  assign pending_o = rbe_expect_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_q <= 0;
      ax_q <= 20'h10000;
      bx_q <= 0;
      a0_q <= 0;
      dd_q <= 20'h10000;
      err_count_o <= 0;
      rbe_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_AB: ab_q <= cfg_data_i;
          CFG_AX: ax_q <= cfg_data_i[19:0];
          CFG_BX: bx_q <= cfg_data_i[19:0];
          CFG_A0: a0_q <= cfg_data_i[19:0];
          CFG_DD: dd_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rbe_expect_q.push_back(predict_rbe(dose_i, let_dose_avg_i));
      if (out_valid_i && !out_stall_i) begin
        if (rbe_expect_q.size() == 0) begin
          if (err_count_o < 10) $display("unexpected beat rbe=%h clipped=%b", rbe_i, clipped_i);
          err_count_o <= err_count_o + 1;
        end else begin
          rbe_res_t e;
          e = rbe_expect_q.pop_front();
          if (e.rbe !== rbe_i || e.clipped !== clipped_i) begin
            if (err_count_o < 10)
              $display("mismatch: expected rbe=%h clipped=%b, got rbe=%h clipped=%b",
                       e.rbe, e.clipped, rbe_i, clipped_i);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[sim/mkm_let_rbe_from_dose_tb.sv]
module mkm_let_rbe_from_dose_tb;
  import mkm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [23:0]         dose_i = '0;
  logic [19:0]         let_dose_avg_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [23:0]         rbe_o;
  logic                clipped_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IW-1:0]   cfg_index_i = '0;
  logic [23:0]         cfg_data_i = '0;
  int                  err_count, pending, cycles;
  bit                  in_quiet, out_quiet;

  mkm_let_rbe_from_dose uut (.*);

  mkm_rbe_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .dose_i, .let_dose_avg_i,
    .out_valid_i(out_valid_o), .out_stall_i, .rbe_i(rbe_o), .clipped_i(clipped_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // call just after a rising edge; returns just after the accepting edge
  task automatic send_dose(logic [23:0] d, logic [19:0] l);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    dose_i         <= d;
    let_dose_avg_i <= l;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold until the pipeline has drained
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [23:0] ab, logic [23:0] ax, logic [23:0] bx,
                           logic [23:0] a0, logic [23:0] dd);
    write_reg(CFG_AB, ab);
    write_reg(CFG_AX, ax);
    write_reg(CFG_BX, bx);
    write_reg(CFG_A0, a0);
    write_reg(CFG_DD, dd);
  endtask

  function automatic logic [23:0] rand_dose();
    logic [23:0] d;
    d = 24'($urandom());
    case ($urandom_range(0, 3))
      0: d = d >> $urandom_range(0, 23);
      1: d = d & 24'h0FFFFF;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [19:0] rand_let();
    logic [19:0] l;
    l = 20'($urandom());
    if ($urandom_range(0, 1)) l = l >> $urandom_range(0, 19);
    return l;
  endfunction

  always begin
    int gap;
    @(posedge clk_i);
    if (rst_ni) begin
      gap = out_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      forever begin
        @(negedge clk_i);
        if (out_valid_o) break;
      end
    end
  end

  initial begin
    logic [23:0] dir_dose[8];
    logic [19:0] dir_let[8];
    dir_dose = '{24'd0, 24'hFFFFFF, 24'd1, 24'h010000, 24'h800000, 24'h000100,
                 24'h0A0000, 24'h7FFFFF};
    dir_let  = '{20'd0, 20'hFFFFF, 20'd1, 20'h00400, 20'h80000, 20'h7FFFF,
                 20'h02800, 20'h00001};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, corners of both fields
    for (int i = 0; i < 8; i++) send_dose(dir_dose[i], dir_let[(i * 3) % 8]);
    for (int i = 0; i < 4; i++) send_dose(dir_dose[i + 4], dir_let[i]);
    drain();
    // typical tissue: ab 10 Gy, ax 0.1, bx 0.05, a0 0.1, dd 0.5 um
    load_regs(24'h0A0000, 24'd6554, 24'd3277, 24'd6554, 24'h08000);
    for (int i = 0; i < 8; i++) send_dose(dir_dose[i], dir_let[i]);
    drain();
    // zero divisors, then unlisted indexes that must be ignored
    load_regs(24'h0A0000, 24'd0, 24'd3277, 24'd6554, 24'h08000);
    send_dose(24'h010000, 20'h00400);
    send_dose(24'd0, 20'h00400);
    drain();
    load_regs(24'h0A0000, 24'd6554, 24'd3277, 24'd6554, 24'd0);
    write_reg(3'd5, 24'hFFFFFF);
    write_reg(3'd6, 24'h123456);
    write_reg(3'd7, 24'hABCDEF);
    send_dose(24'h020000, 20'h00400);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_regs(24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd1);
        1: load_regs(24'd0, 24'hFFFFF, 24'd0, 24'd0, 24'hFFFFF);
        2: load_regs(24'h020000, 24'd19661, 24'd3277, 24'd9830, 24'h0B333);
        3: load_regs(24'($urandom()), 24'($urandom() | 32'd1), 24'($urandom()),
                     24'($urandom()), 24'($urandom() | 32'd1));
        4: load_regs(24'($urandom() >> 4), 24'($urandom_range(1, 1048575)),
                     24'($urandom() >> 8), 24'($urandom() >> 6),
                     24'($urandom_range(16384, 1048575)));
        default: load_regs(24'h0C0000, 24'd13107, 24'd2000, 24'd13107,
                           24'($urandom_range(1, 1048575)));
      endcase
      for (int i = 0; i < 115; i++) begin
        if (i % 40 == 0) begin
          in_quiet  = ($urandom_range(0, 3) == 0);
          out_quiet = ($urandom_range(0, 3) == 0);
        end
        if (ph == 2 && i == 60) begin
          in_valid_i <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        send_dose(rand_dose(), rand_let());
      end
      in_quiet  = 0;
      out_quiet = 0;
      drain();
    end

    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
